// File: rtl/lbbc_pkg.sv
// shared types and constants for the lru block buffer cache with mirror steering
package lbbc_pkg;

   localparam int NUM_BUFFERS_DEF = 32;

   localparam logic [7:0] REFS_MAX = 8'hFF;

   typedef enum logic [2:0] {
      FUNC_READ    = 3'd0,
      FUNC_WRITE   = 3'd1,
      FUNC_RELEASE = 3'd2,
      FUNC_PIN     = 3'd3,
      FUNC_UNPIN   = 3'd4
   } func_type;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE   = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   localparam logic [1:0] CSR_MIRROR_OFFSET = 2'd0;
   localparam logic [1:0] CSR_FAILED_DISK   = 2'd1;
   localparam logic [1:0] CSR_FAILED_BLOCK  = 2'd2;

   localparam logic signed [1:0] FAILED_PRIMARY = 2'sd0;
   localparam logic signed [1:0] FAILED_MIRROR  = 2'sd1;

   typedef struct packed {
      logic [2:0]  func;
      logic [3:0]  device;
      logic [23:0] block;
      logic [4:0]  slot;
   } req_type;

   typedef struct packed {
      logic [4:0]  slot_out;
      logic [1:0]  status;
      logic        hit;
      logic        disk_read;
      logic [24:0] read_block;
      logic        write_primary;
      logic        write_mirror;
      logic [23:0] primary_block;
      logic [24:0] mirror_block;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_RANK,
      ST_PICK,
      ST_SEL,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic capture;
      logic match_en;
      logic rank_en;
      logic pick_en;
      logic sel_en;
      logic exec_en;
   } cmd_type;

   typedef struct packed {
      logic new_is_read;
   } stat_type;

endpackage

// File: rtl/lbbc_ctrl.sv
// controller state machine: sequences lookup stages and the execute step
module lbbc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  lbbc_pkg::stat_type stat,
   output logic              busy,
   output lbbc_pkg::cmd_type cmd
);

   lbbc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbbc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         lbbc_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               // reads walk the lookup stages, everything else executes directly
               state_in = stat.new_is_read ? lbbc_pkg::ST_MATCH : lbbc_pkg::ST_EXEC;
            end
         end
         lbbc_pkg::ST_MATCH: begin
            cmd.match_en = 1'b1;
            state_in     = lbbc_pkg::ST_RANK;
         end
         lbbc_pkg::ST_RANK: begin
            cmd.rank_en = 1'b1;
            state_in    = lbbc_pkg::ST_PICK;
         end
         lbbc_pkg::ST_PICK: begin
            cmd.pick_en = 1'b1;
            state_in    = lbbc_pkg::ST_SEL;
         end
         lbbc_pkg::ST_SEL: begin
            cmd.sel_en = 1'b1;
            state_in   = lbbc_pkg::ST_EXEC;
         end
         lbbc_pkg::ST_EXEC: begin
            cmd.exec_en = 1'b1;
            state_in    = lbbc_pkg::ST_IDLE;
         end
         default: begin
            state_in = lbbc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/lbbc_dp.sv
// datapath: slot table, recency ranks, lookup stages, config registers, response register
module lbbc_dp #(
   parameter int NUM_BUFFERS = lbbc_pkg::NUM_BUFFERS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  lbbc_pkg::req_type req_payload,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [24:0]       csr_wdata,
   input  lbbc_pkg::cmd_type cmd,
   output lbbc_pkg::stat_type stat,
   output logic              rsp_valid,
   output lbbc_pkg::rsp_type rsp_payload
);

   localparam int IDX_W = $clog2(NUM_BUFFERS);
   localparam logic [8:0] SLOT_LIM = 9'(NUM_BUFFERS);

   // slot table
   logic [3:0]       entry_device_ff [NUM_BUFFERS];
   logic [23:0]      entry_block_ff  [NUM_BUFFERS];
   logic             entry_valid_ff  [NUM_BUFFERS];
   logic [7:0]       entry_refs_ff   [NUM_BUFFERS];
   logic [IDX_W-1:0] entry_rank_ff   [NUM_BUFFERS];
   logic [3:0]       entry_device_in [NUM_BUFFERS];
   logic [23:0]      entry_block_in  [NUM_BUFFERS];
   logic             entry_valid_in  [NUM_BUFFERS];
   logic [7:0]       entry_refs_in   [NUM_BUFFERS];
   logic [IDX_W-1:0] entry_rank_in   [NUM_BUFFERS];

   // config
   logic [23:0]        mirror_offset_ff;
   logic signed [1:0]  failed_disk_ff;
   logic [24:0]        failed_block_ff;

   // request and lookup pipeline
   lbbc_pkg::req_type  req_ff;
   logic [NUM_BUFFERS-1:0] match_vec_ff, match_vec_in;
   logic [NUM_BUFFERS-1:0] free_vec_ff, free_vec_in;
   logic [NUM_BUFFERS-1:0] hit_by_rank_ff, hit_by_rank_in;
   logic [NUM_BUFFERS-1:0] free_by_rank_ff, free_by_rank_in;
   logic [IDX_W-1:0]   pick_rank_ff, pick_rank_in;
   logic               hit_found_ff, hit_found_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   sel_ff, sel_in;

   lbbc_pkg::rsp_type  rsp_ff, rsp_in;
   logic               rsp_valid_ff;

   logic [IDX_W-1:0]   exec_idx;
   logic               slot_ok;
   logic [7:0]         refs_cur;
   logic [23:0]        blk_cur;
   logic               valid_eff;
   logic               forced;

   function automatic logic primary_fails(input logic signed [1:0] fd,
                                          input logic [24:0] fb,
                                          input logic [23:0] b);
      primary_fails = (fd == lbbc_pkg::FAILED_PRIMARY) || (!fb[24] && fb[23:0] == b);
   endfunction

   assign stat.new_is_read = (req_payload.func == lbbc_pkg::FUNC_READ);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // stage 1: per-slot key compare and free flag
   always_comb begin
      for (int j = 0; j < NUM_BUFFERS; j++) begin
         match_vec_in[j] = (entry_device_ff[j] == req_ff.device) &&
                           (entry_block_ff[j] == req_ff.block);
         free_vec_in[j]  = (entry_refs_ff[j] == 8'd0);
      end
   end

   // stage 2: scatter the flags into rank order (ranks are a permutation)
   always_comb begin
      hit_by_rank_in  = '0;
      free_by_rank_in = '0;
      for (int r = 0; r < NUM_BUFFERS; r++) begin
         for (int j = 0; j < NUM_BUFFERS; j++) begin
            if (entry_rank_ff[j] == IDX_W'(r)) begin
               hit_by_rank_in[r]  = hit_by_rank_in[r]  | match_vec_ff[j];
               free_by_rank_in[r] = free_by_rank_in[r] | free_vec_ff[j];
            end
         end
      end
   end

   // stage 3: most recent match, else least recent free slot
   always_comb begin
      logic [IDX_W-1:0] lo_hit;
      logic [IDX_W-1:0] hi_free;
      lo_hit        = '0;
      hi_free       = '0;
      hit_found_in  = |hit_by_rank_ff;
      free_found_in = |free_by_rank_ff;
      for (int r = NUM_BUFFERS - 1; r >= 0; r--) begin
         if (hit_by_rank_ff[r]) begin
            lo_hit = IDX_W'(r);
         end
      end
      for (int r = 0; r < NUM_BUFFERS; r++) begin
         if (free_by_rank_ff[r]) begin
            hi_free = IDX_W'(r);
         end
      end
      pick_rank_in = hit_found_in ? lo_hit : hi_free;
   end

   // stage 4: map the chosen rank back to its slot
   always_comb begin
      sel_in = '0;
      for (int j = 0; j < NUM_BUFFERS; j++) begin
         if (entry_rank_ff[j] == pick_rank_ff) begin
            sel_in = IDX_W'(j);
         end
      end
   end

   assign exec_idx = (req_ff.func == lbbc_pkg::FUNC_READ) ? sel_ff : IDX_W'(req_ff.slot);
   assign slot_ok  = ({4'b0, req_ff.slot} < SLOT_LIM);
   assign refs_cur = entry_refs_ff[exec_idx];
   assign blk_cur  = entry_block_ff[exec_idx];
   assign forced   = primary_fails(failed_disk_ff, failed_block_ff, req_ff.block);

   // execute step: table update and result
   always_comb begin
      rsp_in    = '0;
      valid_eff = entry_valid_ff[exec_idx];
      for (int j = 0; j < NUM_BUFFERS; j++) begin
         entry_device_in[j] = entry_device_ff[j];
         entry_block_in[j]  = entry_block_ff[j];
         entry_valid_in[j]  = entry_valid_ff[j];
         entry_refs_in[j]   = entry_refs_ff[j];
         entry_rank_in[j]   = entry_rank_ff[j];
      end
      case (req_ff.func)
         lbbc_pkg::FUNC_READ: begin
            if (!hit_found_ff && !free_found_ff) begin
               rsp_in.status = lbbc_pkg::STATUS_NO_FREE;
            end else begin
               rsp_in.slot_out = 5'(exec_idx);
               rsp_in.hit      = hit_found_ff;
               if (hit_found_ff) begin
                  if (refs_cur != lbbc_pkg::REFS_MAX) begin
                     entry_refs_in[exec_idx] = refs_cur + 8'd1;
                  end
               end else begin
                  // recycle the slot
                  entry_device_in[exec_idx] = req_ff.device;
                  entry_block_in[exec_idx]  = req_ff.block;
                  entry_refs_in[exec_idx]   = 8'd1;
                  valid_eff                 = 1'b0;
               end
               if (!valid_eff || forced) begin
                  rsp_in.disk_read  = 1'b1;
                  rsp_in.read_block = forced ? {1'b0, req_ff.block} + {1'b0, mirror_offset_ff}
                                             : {1'b0, req_ff.block};
                  entry_valid_in[exec_idx] = 1'b1;
               end
            end
         end
         lbbc_pkg::FUNC_WRITE: begin
            rsp_in.slot_out = req_ff.slot;
            if (slot_ok) begin
               rsp_in.write_primary = !primary_fails(failed_disk_ff, failed_block_ff, blk_cur);
               rsp_in.write_mirror  = (failed_disk_ff != lbbc_pkg::FAILED_MIRROR);
               rsp_in.primary_block = blk_cur;
               rsp_in.mirror_block  = {1'b0, blk_cur} + {1'b0, mirror_offset_ff};
            end
         end
         lbbc_pkg::FUNC_RELEASE: begin
            rsp_in.slot_out = req_ff.slot;
            if (slot_ok) begin
               if (refs_cur == 8'd0) begin
                  rsp_in.status = lbbc_pkg::STATUS_UNDERFLOW;
               end else begin
                  entry_refs_in[exec_idx] = refs_cur - 8'd1;
                  if (refs_cur == 8'd1) begin
                     // last reference gone: slot becomes most recent
                     for (int j = 0; j < NUM_BUFFERS; j++) begin
                        if (entry_rank_ff[j] < entry_rank_ff[exec_idx]) begin
                           entry_rank_in[j] = entry_rank_ff[j] + IDX_W'(1);
                        end
                     end
                     entry_rank_in[exec_idx] = '0;
                  end
               end
            end
         end
         lbbc_pkg::FUNC_PIN: begin
            rsp_in.slot_out = req_ff.slot;
            if (slot_ok && refs_cur != lbbc_pkg::REFS_MAX) begin
               entry_refs_in[exec_idx] = refs_cur + 8'd1;
            end
         end
         lbbc_pkg::FUNC_UNPIN: begin
            rsp_in.slot_out = req_ff.slot;
            if (slot_ok) begin
               if (refs_cur == 8'd0) begin
                  rsp_in.status = lbbc_pkg::STATUS_UNDERFLOW;
               end else begin
                  entry_refs_in[exec_idx] = refs_cur - 8'd1;
               end
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // lookup pipeline and request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      if (cmd.match_en) begin
         match_vec_ff <= match_vec_in;
         free_vec_ff  <= free_vec_in;
      end
      if (cmd.rank_en) begin
         hit_by_rank_ff  <= hit_by_rank_in;
         free_by_rank_ff <= free_by_rank_in;
      end
      if (cmd.pick_en) begin
         pick_rank_ff  <= pick_rank_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
      end
      if (cmd.sel_en) begin
         sel_ff <= sel_in;
      end
      if (cmd.exec_en) begin
         rsp_ff <= rsp_in;
      end
   end

   // slot table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NUM_BUFFERS; j++) begin
            entry_device_ff[j] <= '0;
            entry_block_ff[j]  <= '0;
            entry_valid_ff[j]  <= 1'b0;
            entry_refs_ff[j]   <= '0;
            entry_rank_ff[j]   <= IDX_W'(NUM_BUFFERS - 1 - j);
         end
      end else if (cmd.exec_en) begin
         for (int j = 0; j < NUM_BUFFERS; j++) begin
            entry_device_ff[j] <= entry_device_in[j];
            entry_block_ff[j]  <= entry_block_in[j];
            entry_valid_ff[j]  <= entry_valid_in[j];
            entry_refs_ff[j]   <= entry_refs_in[j];
            entry_rank_ff[j]   <= entry_rank_in[j];
         end
      end
   end

   // config registers and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_offset_ff <= 24'd2000;
         failed_disk_ff   <= -2'sd1;
         failed_block_ff  <= '1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.exec_en;
         if (csr_we) begin
            case (csr_index)
               lbbc_pkg::CSR_MIRROR_OFFSET: mirror_offset_ff <= csr_wdata[23:0];
               lbbc_pkg::CSR_FAILED_DISK:   failed_disk_ff   <= csr_wdata[1:0];
               lbbc_pkg::CSR_FAILED_BLOCK:  failed_block_ff  <= csr_wdata;
               default: begin
                  mirror_offset_ff <= mirror_offset_ff;
               end
            endcase
         end
      end
   end

endmodule

// File: rtl/lru_block_buffer_cache_mirror_top.sv
// top level of the lru block buffer cache with refcounts and mirror steering
//
//   channel   ports                              beat taken when
//   request   start, busy, req_payload           start high and busy low
//   result    rsp_valid, rsp_payload             rsp_valid high (one cycle, no stall)
//   config    csr_we, csr_index, csr_wdata       csr_we high
//
// a read goes from accept to result through key compare, rank scatter,
// rank pick, slot select and execute, each one registered step.
// write, release, pin, unpin and unknown codes skip the lookup and go straight to execute.
// reset is synchronous, active high, and clears the table.
// the result strobe lasts one cycle; the receiver cannot stall it.
module lru_block_buffer_cache_mirror_top #(
   parameter int NUM_BUFFERS = lbbc_pkg::NUM_BUFFERS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lbbc_pkg::req_type req_payload,
   output logic              rsp_valid,
   output lbbc_pkg::rsp_type rsp_payload,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [24:0]       csr_wdata
);

   lbbc_pkg::cmd_type  cmd;
   lbbc_pkg::stat_type stat;

   lbbc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   lbbc_dp #(
      .NUM_BUFFERS (NUM_BUFFERS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
